>>> rtl/psc_pkg.sv
// psc_pkg: types, constants and microcode ROM of the PID speed controller.
// Used by pid_speed_controller; depends on nothing else.
`default_nettype none

package psc_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_SPEED = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_I       = 3'd2,
    REG_GAIN_D       = 3'd3,
    REG_MAX_PWM      = 3'd4
  } cfg_reg_e;

  localparam logic [15:0] RST_TARGET_SPEED = 16'd1280;
  localparam logic [15:0] RST_GAIN_P       = 16'd7680;
  localparam logic [15:0] RST_GAIN_I       = 16'd3328;
  localparam logic [15:0] RST_GAIN_D       = 16'd1280;
  localparam logic [7:0]  RST_MAX_PWM      = 8'd255;

  // datapath widths
  localparam int unsigned ERR_W   = 17;  // target - speed, signed Q8.8
  localparam int unsigned INTEG_W = 48;  // saturating integral
  localparam int unsigned MUL_A_W = 17;
  localparam int unsigned MUL_B_W = 29;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned DIFFK_W = 28;  // (error - previous error) * 1000
  localparam int unsigned ACC_W   = 64;  // gain_i * integral
  localparam int unsigned SUM_W   = 48;  // P + I + D in Q.16
  localparam int unsigned LIM_W   = 24;  // max_pwm in Q.16

  // restoring divider for the derivative, one quotient bit per step
  localparam int unsigned DIV_W   = 44;
  localparam int unsigned I_BITS  = 34;  // |gain_i * integral| below the clamp bound
  localparam int unsigned D_BITS  = 42;  // |gain_d * diff * 1000|
  localparam int unsigned CNT_W   = 6;

  // x / 1000 = (x / 8) / 125, the last step by reciprocal multiply;
  // exact for x / 8 below 2^35 / 7
  localparam int unsigned RCP_IN_W = I_BITS - 3;
  localparam int unsigned RCP_W    = 29;
  localparam int unsigned RCP_SH   = 35;
  localparam int unsigned RCP_Q_W  = RCP_IN_W + RCP_W - RCP_SH;
  localparam logic [RCP_W-1:0] RCP_125 = 29'd274877907;  // ceil(2^35 / 125)

  // microcode
  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERR_DT,
    MUL_GI_HI,
    MUL_GI_LO,
    MUL_GP_ERR,
    MUL_GD_DIFF
  } mul_sel_e;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_ACCEPT,
    ALU_INTEG,
    ALU_ACC_SET,
    ALU_ACC_ADD,
    ALU_ILIM,
    ALU_IRECIP,
    ALU_DIV,
    ALU_IFIN,
    ALU_SUM_ADD,
    ALU_DIFF,
    ALU_DLOAD,
    ALU_DFIN,
    ALU_OUT
  } alu_e;

  typedef enum logic [1:0] {
    COND_SEQ,
    COND_ALWAYS,
    COND_ICLAMP,
    COND_DIV_MORE
  } cond_e;

  typedef struct packed {
    hold_e    hold;
    mul_sel_e mul;
    alu_e     alu;
    cond_e    cond;
    pc_t      target;
  } uword_t;

  localparam pc_t PC_IDLE    = 4'd0;
  localparam pc_t PC_MUL_EDT = 4'd1;
  localparam pc_t PC_INTEG   = 4'd2;
  localparam pc_t PC_MUL_IHI = 4'd3;
  localparam pc_t PC_ACC_HI  = 4'd4;
  localparam pc_t PC_MUL_ILO = 4'd5;
  localparam pc_t PC_ACC_LO  = 4'd6;
  localparam pc_t PC_ILIM    = 4'd7;
  localparam pc_t PC_IDIV    = 4'd8;
  localparam pc_t PC_IFIN    = 4'd9;
  localparam pc_t PC_PTERM   = 4'd10;
  localparam pc_t PC_PADD    = 4'd11;
  localparam pc_t PC_DLOAD   = 4'd12;
  localparam pc_t PC_DDIV    = 4'd13;
  localparam pc_t PC_DFIN    = 4'd14;
  localparam pc_t PC_OUT     = 4'd15;

  // Program: a conditional jump goes to target, otherwise to the next step.
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    w = '{HOLD_NONE, MUL_NONE, ALU_NOP, COND_ALWAYS, PC_IDLE};
    case (pc)
      PC_IDLE:    w = '{HOLD_IN,   MUL_NONE,    ALU_ACCEPT,  COND_SEQ,      PC_IDLE};
      PC_MUL_EDT: w = '{HOLD_NONE, MUL_ERR_DT,  ALU_NOP,     COND_SEQ,      PC_IDLE};
      PC_INTEG:   w = '{HOLD_NONE, MUL_NONE,    ALU_INTEG,   COND_SEQ,      PC_IDLE};
      PC_MUL_IHI: w = '{HOLD_NONE, MUL_GI_HI,   ALU_NOP,     COND_SEQ,      PC_IDLE};
      PC_ACC_HI:  w = '{HOLD_NONE, MUL_NONE,    ALU_ACC_SET, COND_SEQ,      PC_IDLE};
      PC_MUL_ILO: w = '{HOLD_NONE, MUL_GI_LO,   ALU_NOP,     COND_SEQ,      PC_IDLE};
      PC_ACC_LO:  w = '{HOLD_NONE, MUL_NONE,    ALU_ACC_ADD, COND_SEQ,      PC_IDLE};
      PC_ILIM:    w = '{HOLD_NONE, MUL_NONE,    ALU_ILIM,    COND_ICLAMP,   PC_PTERM};
      PC_IDIV:    w = '{HOLD_NONE, MUL_NONE,    ALU_IRECIP,  COND_SEQ,      PC_IDLE};
      PC_IFIN:    w = '{HOLD_NONE, MUL_NONE,    ALU_IFIN,    COND_SEQ,      PC_IDLE};
      PC_PTERM:   w = '{HOLD_NONE, MUL_GP_ERR,  ALU_DIFF,    COND_SEQ,      PC_IDLE};
      PC_PADD:    w = '{HOLD_NONE, MUL_GD_DIFF, ALU_SUM_ADD, COND_SEQ,      PC_IDLE};
      PC_DLOAD:   w = '{HOLD_NONE, MUL_NONE,    ALU_DLOAD,   COND_SEQ,      PC_IDLE};
      PC_DDIV:    w = '{HOLD_NONE, MUL_NONE,    ALU_DIV,     COND_DIV_MORE, PC_DDIV};
      PC_DFIN:    w = '{HOLD_NONE, MUL_NONE,    ALU_DFIN,    COND_SEQ,      PC_IDLE};
      PC_OUT:     w = '{HOLD_OUT,  MUL_NONE,    ALU_OUT,     COND_ALWAYS,   PC_IDLE};
      default:    w = '{HOLD_NONE, MUL_NONE,    ALU_NOP,     COND_ALWAYS,   PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/pid_speed_controller.sv
// pid_speed_controller: positional PID speed controller, microcoded datapath.
// Depends on psc_pkg (microcode ROM, widths, register indexes).
//
//   channel | signals                                 | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid_i, in_ready_o,                 | input
//           | measured_speed_i, interval_ms_i         |
//   out     | out_valid_o, out_ready_i,               | output
//           | drive_o, output_clamped_o               |
//   cfg     | cfg_valid_i, cfg_ready_o,               | input
//           | cfg_index_i, cfg_data_i                 |
//
// An item runs through the program from input transfer to result; the integral
// divide steps are skipped when the integral term hits its clamp, and the 42-step
// 1-bit-per-cycle divide by the interval makes up most of the run. A new item
// is taken only when the program is back at its idle step, in the cycle after
// the result is loaded, so items do not overlap. The result sits in an output
// register, so the next item is accepted while it waits; the program holds at
// its last step only if that register is still full. Reset clears the integral
// and previous error and loads the register defaults. cfg_ready_o is always high.
`default_nettype none

module pid_speed_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [15:0]                      measured_speed_i,
  input  logic [15:0]                      interval_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       drive_o,
  output logic                             output_clamped_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [psc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [psc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import psc_pkg::*;

  // configuration
  logic [15:0] target_q, gain_p_q, gain_i_q, gain_d_q;
  logic [7:0]  max_pwm_q;

  // sequencer
  pc_t    pc_q, pc_d;
  uword_t uw;
  logic   stall, go, take, fire_out;

  // state and datapath
  logic [ERR_W-1:0]   err_q, prev_q;
  logic [15:0]        dt_q, den_q;
  logic [INTEG_W-1:0] integ_q;
  logic [PROD_W-1:0]  prod_q;
  logic [ACC_W-1:0]   acc_q;
  logic [DIFFK_W-1:0] diffk_q;
  logic [SUM_W-1:0]   sum_q;
  logic [DIV_W-1:0]   quo_q;
  logic [15:0]        rem_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               neg_q;

  logic               out_valid_q, clamped_q;
  logic [7:0]         drive_q;

  // combinational datapath
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic [ERR_W-1:0]          err_new;
  logic [15:0]               dt_new;
  logic [INTEG_W:0]          integ_sum;
  logic [INTEG_W-1:0]        integ_sat;
  logic [ACC_W-1:0]          acc_mag;
  logic [LIM_W-1:0]          lim1;
  logic [I_BITS-1:0]         ibound;
  logic                      iclamp;
  logic [SUM_W-1:0]          lim48;
  logic [PROD_W-1:0]         dmag;
  logic [ERR_W:0]            diff;
  logic [DIFFK_W-1:0]        diffx, diffk;
  logic [16:0]               div_sh;
  logic [17:0]               div_trial;
  logic [RCP_IN_W+RCP_W-1:0] rcp_p;
  logic [SUM_W-1:0]          quo_s, quo_signed;
  logic                      sum_over;

  assign uw = ucode_rom(pc_q);

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= RST_TARGET_SPEED;
      gain_p_q  <= RST_GAIN_P;
      gain_i_q  <= RST_GAIN_I;
      gain_d_q  <= RST_GAIN_D;
      max_pwm_q <= RST_MAX_PWM;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_TARGET_SPEED: target_q  <= cfg_data_i;
        REG_GAIN_P:       gain_p_q  <= cfg_data_i;
        REG_GAIN_I:       gain_i_q  <= cfg_data_i;
        REG_GAIN_D:       gain_d_q  <= cfg_data_i;
        REG_MAX_PWM:      max_pwm_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- sequencer
  always_comb begin
    case (uw.hold)
      HOLD_IN:  stall = !in_valid_i;
      HOLD_OUT: stall = out_valid_q && !out_ready_i;
      default:  stall = 1'b0;
    endcase
    case (uw.cond)
      COND_ALWAYS:   take = 1'b1;
      COND_ICLAMP:   take = iclamp;
      COND_DIV_MORE: take = (cnt_q != CNT_W'(1));
      default:       take = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + pc_t'(1);
    end
  end

  always_comb begin
    go         = !stall;
    fire_out   = go && (uw.alu == ALU_OUT);
    in_ready_o = (uw.hold == HOLD_IN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  // -------------------------------------------------------------- datapath
  assign err_new = {1'b0, target_q} - {1'b0, measured_speed_i};
  assign dt_new  = (interval_ms_i == 16'd0) ? 16'd1 : interval_ms_i;

  always_comb begin
    case (uw.mul)
      MUL_ERR_DT: begin
        mul_a = signed'(err_q);
        mul_b = signed'({13'd0, dt_q});
      end
      MUL_GI_HI: begin
        mul_a = signed'({gain_i_q[15], gain_i_q});
        mul_b = signed'({{5{integ_q[INTEG_W-1]}}, integ_q[INTEG_W-1:24]});
      end
      MUL_GI_LO: begin
        mul_a = signed'({gain_i_q[15], gain_i_q});
        mul_b = signed'({5'd0, integ_q[23:0]});
      end
      MUL_GP_ERR: begin
        mul_a = signed'({gain_p_q[15], gain_p_q});
        mul_b = signed'({{12{err_q[ERR_W-1]}}, err_q});
      end
      MUL_GD_DIFF: begin
        mul_a = signed'({gain_d_q[15], gain_d_q});
        mul_b = signed'({diffk_q[DIFFK_W-1], diffk_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // saturating integral update
  assign integ_sum = {integ_q[INTEG_W-1], integ_q}
                   + {{(INTEG_W+1-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  always_comb begin
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end
  end

  // integral clamp: |gain_i * integral| >= (limit + 1) * 1000 means the
  // quotient is beyond the limit, so the divide by 1000 is skipped
  assign acc_mag = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
  assign lim1    = {max_pwm_q, 16'd1};
  assign ibound  = {lim1, 10'd0} - {6'd0, lim1, 4'd0} - {7'd0, lim1, 3'd0};
  assign iclamp  = (acc_mag >= {{(ACC_W-I_BITS){1'b0}}, ibound});
  assign lim48   = {{(SUM_W-LIM_W){1'b0}}, max_pwm_q, 16'd0};

  // quo_q holds |gain_i * integral| / 8 here; times ceil(2^35 / 125)
  assign rcp_p = quo_q[RCP_IN_W-1:0] * RCP_125;

  assign dmag = prod_q[PROD_W-1] ? (PROD_W'(0) - prod_q) : prod_q;

  // (error - previous error) * 1000 by shift and subtract
  assign diff  = {err_q[ERR_W-1], err_q} - {prev_q[ERR_W-1], prev_q};
  assign diffx = {{(DIFFK_W-ERR_W-1){diff[ERR_W]}}, diff};
  assign diffk = (diffx << 10) - (diffx << 4) - (diffx << 3);

  // one restoring divide step
  assign div_sh    = {rem_q, quo_q[DIV_W-1]};
  assign div_trial = {1'b0, div_sh} - {2'b0, den_q};

  assign quo_s      = {{(SUM_W-DIV_W){1'b0}}, quo_q};
  assign quo_signed = neg_q ? (SUM_W'(0) - quo_s) : quo_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
      cnt_q   <= '0;
    end else if (go) begin
      case (uw.alu)
        ALU_INTEG: integ_q <= integ_sat;
        ALU_DIFF:  prev_q  <= err_q;
        ALU_DLOAD: cnt_q   <= CNT_W'(D_BITS);
        ALU_DIV:   cnt_q   <= cnt_q - CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && (uw.mul != MUL_NONE)) begin
      prod_q <= mul_p;
    end
    if (go) begin
      case (uw.alu)
        ALU_ACCEPT: begin
          err_q <= err_new;
          dt_q  <= dt_new;
        end
        ALU_ACC_SET: acc_q <= {prod_q[39:0], 24'd0};
        ALU_ACC_ADD: acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
        ALU_ILIM: begin
          sum_q <= acc_q[ACC_W-1] ? (SUM_W'(0) - lim48) : lim48;
          quo_q <= {{(DIV_W-RCP_IN_W){1'b0}}, acc_mag[I_BITS-1:3]};
          neg_q <= acc_q[ACC_W-1];
        end
        ALU_IRECIP: quo_q <= {{(DIV_W-RCP_Q_W){1'b0}}, rcp_p[RCP_IN_W+RCP_W-1:RCP_SH]};
        ALU_DIV: begin
          if (!div_trial[17]) begin
            rem_q <= div_trial[15:0];
            quo_q <= {quo_q[DIV_W-2:0], 1'b1};
          end else begin
            rem_q <= div_sh[15:0];
            quo_q <= {quo_q[DIV_W-2:0], 1'b0};
          end
        end
        ALU_IFIN:    sum_q   <= quo_signed;
        ALU_DIFF:    diffk_q <= diffk;
        ALU_SUM_ADD: sum_q   <= sum_q + {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
        ALU_DLOAD: begin
          quo_q <= {dmag[D_BITS-1:0], {(DIV_W-D_BITS){1'b0}}};
          rem_q <= '0;
          den_q <= dt_q;
          neg_q <= prod_q[PROD_W-1];
        end
        ALU_DFIN:    sum_q   <= sum_q + quo_signed;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- output
  assign sum_over = !sum_q[SUM_W-1] && (sum_q > lim48);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_out) begin
      if (sum_q[SUM_W-1]) begin
        drive_q <= 8'd0;
      end else if (sum_over) begin
        drive_q <= max_pwm_q;
      end else begin
        drive_q <= sum_q[23:16];
      end
      clamped_q <= sum_q[SUM_W-1] || sum_over;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_o          = drive_q;
  assign output_clamped_o = clamped_q;

  // ------------------------------------------------------------ assertions
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.alu == ALU_DIV) |-> (cnt_q != '0))
    else $error("divider step with exhausted count");

  a_iterm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.alu == ALU_IFIN) |-> (quo_q <= {{(DIV_W-LIM_W){1'b0}}, lim48[LIM_W-1:0]}))
    else $error("unclamped integral term beyond limit");

  a_dterm_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.alu == ALU_DLOAD) |-> (dmag[PROD_W-1:D_BITS] == '0))
    else $error("derivative dividend exceeds divider width");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(fire_out))
    else $error("result valid without output step");

  a_drive_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_o <= max_pwm_q))
    else $error("drive above max_pwm");

endmodule

`default_nettype wire

>>> tb/pid_speed_controller_tb.sv
// pid_speed_controller_tb: self-checking testbench of the PID speed controller.
// Depends on psc_pkg and pid_speed_controller; a cycle-free predictor written
// here computes each drive value, which is checked as results come back.
`default_nettype none

module pid_speed_controller_tb;
  import psc_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 6;
  localparam int TIMEOUT_CYCLES  = 2_000_000;
  localparam int SETTLE_CYCLES   = 150;   // longer than one item's latency
  localparam int HOLDOFF_CYCLES  = 400;
  localparam int MAX_REPORTS     = 10;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLDOFF_PHASE   = 0;
  localparam int PAUSE_PHASE     = 4;
  localparam int N_DIR           = 34;

  localparam longint MS_PER_SEC = 1000;
  localparam longint INTEG_HI   = (longint'(1) << 47) - 1;
  localparam longint INTEG_LO   = -INTEG_HI - 1;

  // indexes past the register map; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_LO = CFG_IDX_W'(REG_MAX_PWM + 1);
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_HI = CFG_IDX_W'(2**CFG_IDX_W - 1);

  typedef struct packed {
    logic [7:0] drive;
    logic       clamped;
  } pwm_result_t;

  typedef struct packed {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          data;
    logic [15:0]          speed;
    logic [15:0]          dt;
    logic                 typed;
    pwm_result_t          res;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [15:0]           measured_speed_i;
  logic [15:0]           interval_ms_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [7:0]            drive_o;
  logic                  output_clamped_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pid_speed_controller u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .measured_speed_i (measured_speed_i),
    .interval_ms_i    (interval_ms_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_o          (drive_o),
    .output_clamped_o (output_clamped_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // predictor copy of the registers and the controller state
  logic [15:0]        sp_target;
  logic signed [15:0] k_p;
  logic signed [15:0] k_i;
  logic signed [15:0] k_d;
  logic [7:0]         pwm_max;
  longint             last_err;
  longint             err_integral;

  pwm_result_t drive_fifo[$];
  pwm_result_t mon_want;
  int          fail_count = 0;
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int          holdoff_reqs = 0;
  int          holdoff_seen = 0;
  int          holdoff_left = 0;
  dir_row_t    dir_rows[N_DIR];

  function automatic longint clamp_q16(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one control step: updates the integral and previous error, returns drive
  function automatic pwm_result_t predict_drive(input logic [15:0] speed,
                                                input logic [15:0] dt_raw);
    longint dt, limit, err, p_term, i_term, d_term, sum, lim_sum;
    pwm_result_t res;
    dt = (dt_raw == 16'd0) ? longint'(1) : longint'(dt_raw);
    limit = longint'(pwm_max) * 65536;
    err = longint'(sp_target) - longint'(speed);
    p_term = longint'(k_p) * err;
    err_integral = clamp_q16(err_integral + err * dt, INTEG_LO, INTEG_HI);
    i_term = (longint'(k_i) * err_integral) / MS_PER_SEC;
    i_term = clamp_q16(i_term, -limit, limit);
    d_term = (longint'(k_d) * (err - last_err) * MS_PER_SEC) / dt;
    last_err = err;
    sum = p_term + i_term + d_term;
    lim_sum = clamp_q16(sum, 0, limit);
    res.drive = lim_sum[23:16];
    res.clamped = (lim_sum != sum);
    return res;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    case (idx)
      REG_TARGET_SPEED: sp_target = data;
      REG_GAIN_P:       k_p = data;
      REG_GAIN_I:       k_i = data;
      REG_GAIN_D:       k_d = data;
      REG_MAX_PWM:      pwm_max = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 16'h8000;
    if (r < 10) return 16'h7FFF;
    if (r < 13) return 16'h0000;
    if (r < 30) return 16'(-int'($urandom_range(4096)));
    return 16'($urandom_range(4096));
  endfunction

  function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    return '{1'b1, idx, data, 16'd0, 16'd0, 1'b0, 9'd0};
  endfunction

  function automatic dir_row_t item_row(input logic [15:0] speed, input logic [15:0] dt);
    return '{1'b0, CFG_IDX_W'(0), 16'd0, speed, dt, 1'b0, 9'd0};
  endfunction

  function automatic dir_row_t item_chk(input logic [15:0] speed, input logic [15:0] dt,
                                        input logic [7:0] drv, input logic clp);
    return '{1'b0, CFG_IDX_W'(0), 16'd0, speed, dt, 1'b1, {drv, clp}};
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // leaves in_valid_i high after the transfer; the caller lowers it
  task automatic offer_item(input logic [15:0] speed, input logic [15:0] dt,
                            input logic typed, input pwm_result_t typed_res);
    pwm_result_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    measured_speed_i <= speed;
    interval_ms_i <= dt;
    do @(posedge clk_i); while (!in_ready_o);
    pred = predict_drive(speed, dt);
    drive_fifo.push_back(typed ? typed_res : pred);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data,
                           input logic last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (drive_fifo.size() != 0) @(posedge clk_i);
  endtask

  // result side: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (holdoff_seen != holdoff_reqs) begin
      holdoff_seen = holdoff_reqs;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_fifo.size() == 0) begin
        note_failure($sformatf("result with none pending: drive=%0d clamped=%0b",
                               drive_o, output_clamped_o));
      end else begin
        mon_want = drive_fifo.pop_front();
        if (drive_o !== mon_want.drive)
          note_failure($sformatf("drive: expected %0d, got %0d", mon_want.drive, drive_o));
        if (output_clamped_o !== mon_want.clamped)
          note_failure($sformatf("output_clamped: expected %0b, got %0b",
                                 mon_want.clamped, output_clamped_o));
      end
    end
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("pid_speed_controller_tb failed");
    $finish;
  end

  initial begin
    int          r, s, mode;
    logic [15:0] sp, dt, tgt;
    logic [7:0]  lim;

    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    measured_speed_i <= '0;
    interval_ms_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;

    sp_target = RST_TARGET_SPEED;
    k_p = RST_GAIN_P;
    k_i = RST_GAIN_I;
    k_d = RST_GAIN_D;
    pwm_max = RST_MAX_PWM;
    last_err = 0;
    err_integral = 0;

    dir_rows = '{
      item_chk(16'd1280,  16'd1000,  8'd0,   1'b0),  // zero error, sum exactly 0
      item_chk(16'd0,     16'd1000,  8'd240, 1'b0),  // P 150 + I 65 + D 25
      item_chk(16'hFFFF,  16'hFFFF,  8'd0,   1'b1),  // huge negative error
      item_chk(16'd0,     16'd1,     8'd255, 1'b1),  // derivative spike over 1 ms
      item_row(16'd0,     16'd0),                    // zero interval counts as 1
      reg_row(UNMAPPED_LO, 16'h0000),
      reg_row(UNMAPPED_HI, 16'hFFFF),
      reg_row(REG_MAX_PWM, 16'hFF00),                // zero limit, high byte ignored
      item_chk(16'd0,     16'd100,   8'd0,   1'b1),
      item_row(16'd1280,  16'd1000),
      reg_row(REG_MAX_PWM, 16'h0001),
      reg_row(REG_TARGET_SPEED, 16'hFFFF),
      reg_row(REG_GAIN_P, 16'h7FFF),
      reg_row(REG_GAIN_I, 16'h7FFF),
      reg_row(REG_GAIN_D, 16'h7FFF),
      item_row(16'd0,     16'hFFFF),
      item_row(16'hFFFF,  16'd1),
      item_row(16'd0,     16'd0),
      reg_row(REG_TARGET_SPEED, 16'h0000),
      reg_row(REG_GAIN_P, 16'h8000),
      reg_row(REG_GAIN_I, 16'h8000),
      reg_row(REG_GAIN_D, 16'h8000),
      reg_row(REG_MAX_PWM, 16'h00FF),
      item_row(16'hFFFF,  16'd1000),
      item_row(16'd0,     16'hFFFF),
      item_row(16'h8000,  16'h8000),
      item_row(16'h00FF,  16'h0100),
      reg_row(REG_TARGET_SPEED, 16'd1280),
      reg_row(REG_GAIN_P, 16'd256),
      reg_row(REG_GAIN_I, 16'd0),
      reg_row(REG_GAIN_D, 16'd0),
      item_chk(16'd1024,  16'd500,   8'd1,   1'b0),  // 1 km/h error at unity gain
      reg_row(REG_MAX_PWM, 16'h0001),
      item_chk(16'd1024,  16'd500,   8'd1,   1'b0)   // sum lands on the limit
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].is_reg) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].data,
                  (i + 1 == N_DIR) || !dir_rows[i + 1].is_reg);
      end else begin
        offer_item(dir_rows[i].speed, dir_rows[i].dt, dir_rows[i].typed, dir_rows[i].res);
        if ((i + 1 == N_DIR) || dir_rows[i + 1].is_reg) in_valid_i <= 1'b0;
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      r = $urandom_range(9);
      tgt = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(25600, 256));
      r = $urandom_range(9);
      lim = (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'd255 : 8'($urandom_range(255, 1));
      if ($urandom_range(3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(UNMAPPED_HI, UNMAPPED_LO)), 16'($urandom), 1'b0);
      write_reg(REG_TARGET_SPEED, tgt, 1'b0);
      write_reg(REG_GAIN_P, pick_gain(), 1'b0);
      write_reg(REG_GAIN_I, pick_gain(), 1'b0);
      write_reg(REG_GAIN_D, pick_gain(), 1'b0);
      write_reg(REG_MAX_PWM, {8'($urandom), lim}, 1'b1);

      mode = p % 4;
      idle_pct  = (mode == 1) ? 73 : (mode == 3) ? 18 : 0;
      stall_pct = (mode == 2) ? 73 : (mode == 3) ? 18 : 0;
      if (p == HOLDOFF_PHASE) holdoff_reqs++;  // fill the result register, stall input

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(99);
        if (r < 70) begin
          // plausible control step: speed near the setpoint, realistic interval
          s = int'(sp_target) + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(1024));
          sp = (s < 0) ? 16'h0000 : (s > 65535) ? 16'hFFFF : 16'(s);
          dt = 16'($urandom_range(2000, 20));
        end else if (r < 90) begin
          sp = 16'($urandom);
          dt = 16'($urandom);
        end else begin
          sp = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          s = $urandom_range(2);
          dt = (s == 0) ? 16'd0 : (s == 1) ? 16'd1 : 16'hFFFF;
        end
        offer_item(sp, dt, 1'b0, '0);
        if (n == ITEMS_PER_PHASE - 1) begin
          in_valid_i <= 1'b0;
        end else if (p == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) begin
          in_valid_i <= 1'b0;
          drain();
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && drive_fifo.size() == 0) begin
      $display("pid_speed_controller_tb passed");
    end else begin
      $display("pid_speed_controller_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/psc_pkg.sv
rtl/pid_speed_controller.sv
tb/pid_speed_controller_tb.sv
